// File: hw/rtl/csa_pkg.sv
`default_nettype none

package csa_pkg;

  localparam int FREE_SEGS_DEF   = 16;
  localparam int USED_BLOCKS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 21;

  localparam logic [31:0] HEAP_BASE_RST   = 32'd0;
  localparam logic [20:0] HEAP_SIZE_RST   = 21'd65536;
  localparam logic [8:0]  INFO_BYTES_RST  = 9'd16;
  localparam logic [8:0]  HEADER_BYTES_RST = 9'd16;

  typedef enum logic [1:0] {
    REG_HEAP_BASE    = 2'd0,
    REG_HEAP_SIZE    = 2'd1,
    REG_INFO_BYTES   = 2'd2,
    REG_HEADER_BYTES = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_ALLOC_FRONT = 2'd0,
    ACT_ALLOC_REAR  = 2'd1,
    ACT_FREE        = 2'd2,
    ACT_CLEAR       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR,
    S_ARD, S_ACHK, S_SLOT, S_AUPD,
    S_RM, S_RMW,
    S_FURD, S_FUCHK, S_FPRD, S_FPCHK, S_FMRG, S_INSW, S_INSPUT,
    S_SUMRD, S_SUMCHK
  } state_t;

  typedef struct packed {
    logic [31:0] heap_base;
    logic [20:0] heap_size;
    logic [8:0]  info_bytes;
    logic [8:0]  header_bytes;
  } cfg_t;

  // Granule minus one: highest set bit of the alignment, zero taken as one.
  function automatic logic [11:0] granule_mask(input logic [12:0] align);
    logic [12:0] g;
    g = 13'd1;
    for (int b = 0; b < 13; b++) begin
      if (align[b]) g = 13'd1 << b;
    end
    return 12'(g - 13'd1);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/csa_ram.sv
`default_nettype none

module csa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AW-1:0]            raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/csa_core.sv
`default_nettype none

module csa_core
  import csa_pkg::*;
#(
  parameter int FREE_SEGS   = FREE_SEGS_DEF,
  parameter int USED_BLOCKS = USED_BLOCKS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  action,
  input  wire logic [20:0] request_size,
  input  wire logic [12:0] align_bytes,
  input  wire logic [31:0] pointer,
  output      logic        done,
  output      logic [1:0]  status,
  output      logic [31:0] address,
  output      logic [20:0] max_free,
  output      logic [20:0] total_free,
  output      logic [4:0]  used_count
);
  localparam int OB = OFFSET_BITS;
  localparam int FI = $clog2(FREE_SEGS);
  localparam int FC = $clog2(FREE_SEGS + 1);
  localparam int UI = (USED_BLOCKS > 1) ? $clog2(USED_BLOCKS) : 1;
  localparam int UC = $clog2(USED_BLOCKS + 1);
  localparam int NW = ((OB > 22) ? OB : 22) + 1;
  localparam int SW = ((OB + 1) > 21) ? (OB + 1) : 21;

  state_t state, state_next;

  logic [1:0]         act;
  logic [NW-1:0]      need;
  logic [31:0]        ptr;
  status_t            st;
  logic [31:0]        addr;
  logic [FI-1:0]      idx, k;
  logic [FC-1:0]      cnt, pos;
  logic [UI-1:0]      uidx, slot;
  logic [OB-1:0]      hs, hz, s, z, pv_s, pv_z, hi_z;
  logic               have_prev, lo, hi;
  logic [USED_BLOCKS-1:0] used_valid;
  logic [UC-1:0]      used_total;
  logic [OB-1:0]      mx;
  logic [SW-1:0]      tot;

  // memory ports
  logic               fr_we, ur_we;
  logic [FI-1:0]      fr_waddr, fr_raddr;
  logic [UI-1:0]      ur_waddr, ur_raddr;
  logic [2*OB-1:0]    fr_wdata, fr_rdata, ur_wdata, ur_rdata;

  csa_ram #(.WIDTH(2*OB), .DEPTH(FREE_SEGS)) u_free_ram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  csa_ram #(.WIDTH(2*OB), .DEPTH(USED_BLOCKS)) u_used_ram (
    .clk(clk), .we(ur_we), .waddr(ur_waddr), .wdata(ur_wdata),
    .raddr(ur_raddr), .rdata(ur_rdata)
  );

  // combinational helpers
  logic [OB-1:0]  frd_s, frd_z, urd_s, urd_z, hsize, info;
  logic [11:0]    gm1;
  logic [NW-1:0]  need_in;
  logic           front, fit, a_last, u_match, clr_fill;
  logic [FI-1:0]  idx_step;
  logic [OB-1:0]  blk, nst, nsz;
  logic [OB:0]    pv_end, dat_end, blk_end;
  logic [OB-1:0]  m2;
  logic [SW-1:0]  t2;
  logic           sum_last;

  assign frd_s = fr_rdata[2*OB-1:OB];
  assign frd_z = fr_rdata[OB-1:0];
  assign urd_s = ur_rdata[2*OB-1:OB];
  assign urd_z = ur_rdata[OB-1:0];
  assign hsize = OB'(cfg.heap_size);
  assign info  = OB'(cfg.info_bytes);
  assign clr_fill = 32'(cfg.info_bytes) < 32'(cfg.heap_size);

  assign gm1     = granule_mask(align_bytes);
  assign need_in = (NW'(request_size) + NW'(cfg.header_bytes) + NW'(gm1)) & ~NW'(gm1);

  assign front    = (act == ACT_ALLOC_FRONT);
  assign fit      = need <= NW'(frd_z);
  assign a_last   = front ? ((FC'(idx) + FC'(1)) == cnt) : (idx == '0);
  assign idx_step = front ? (idx + FI'(1)) : (idx - FI'(1));

  assign blk = front ? hs : (hs + hz - need[OB-1:0]);
  assign nst = front ? (hs + need[OB-1:0]) : hs;
  assign nsz = hz - need[OB-1:0];

  assign u_match = used_valid[uidx] &&
                   ((cfg.heap_base + 32'(urd_s) + 32'(cfg.header_bytes)) == ptr);

  assign pv_end  = {1'b0, pv_s} + {1'b0, pv_z};
  assign dat_end = {1'b0, frd_s} + {1'b0, frd_z};
  assign blk_end = {1'b0, s} + {1'b0, z};

  assign m2       = (frd_z > mx) ? frd_z : mx;
  assign t2       = tot + SW'(frd_z);
  assign sum_last = (FC'(idx) + FC'(1)) == cnt;

  assign busy = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (action_t'(action))
            ACT_ALLOC_FRONT, ACT_ALLOC_REAR: begin
              if (need_in == '0 || cnt == '0) state_next = S_SUMRD;
              else state_next = S_ARD;
            end
            ACT_FREE: state_next = (pointer == 32'd0) ? S_SUMRD : S_FURD;
            ACT_CLEAR: state_next = S_CLR;
          endcase
        end
      end
      S_CLR: state_next = S_SUMRD;
      S_ARD: state_next = S_ACHK;
      S_ACHK: begin
        if (fit) state_next = S_SLOT;
        else if (a_last) state_next = S_SUMRD;
      end
      S_SLOT: begin
        if (!used_valid[uidx]) state_next = S_AUPD;
        else if (uidx == UI'(USED_BLOCKS - 1)) state_next = S_SUMRD;
      end
      S_AUPD: state_next = (nsz != '0) ? S_SUMRD : S_RM;
      S_RM: state_next = ((FC'(k) + FC'(1)) >= cnt) ? S_SUMRD : S_RMW;
      S_RMW: begin
        if (!((FC + 1)'(k) + (FC + 1)'(2) < (FC + 1)'(cnt))) state_next = S_SUMRD;
      end
      S_FURD: state_next = S_FUCHK;
      S_FUCHK: begin
        if (u_match) state_next = (cnt == '0) ? S_FMRG : S_FPRD;
        else if (uidx == UI'(USED_BLOCKS - 1)) state_next = S_SUMRD;
      end
      S_FPRD: state_next = S_FPCHK;
      S_FPCHK: begin
        if (s < frd_s || (FC'(idx) + FC'(1)) == cnt) state_next = S_FMRG;
      end
      S_FMRG: begin
        priority if (lo && hi) state_next = S_RM;
        else if (lo || hi) state_next = S_SUMRD;
        else if (cnt >= FC'(FREE_SEGS)) state_next = S_SUMRD;
        else if (cnt > pos) state_next = S_INSW;
        else state_next = S_INSPUT;
      end
      S_INSW: begin
        if (!((FC'(k) - FC'(1)) > pos)) state_next = S_INSPUT;
      end
      S_INSPUT: state_next = S_SUMRD;
      S_SUMRD: state_next = (cnt == '0) ? S_IDLE : S_SUMCHK;
      S_SUMCHK: if (sum_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = '0;
    fr_wdata = '0;
    fr_raddr = '0;
    ur_we    = 1'b0;
    ur_waddr = slot;
    ur_wdata = {blk, need[OB-1:0]};
    ur_raddr = uidx;
    unique case (state)
      S_INIT, S_CLR: begin
        fr_we    = clr_fill;
        fr_wdata = {info, hsize - info};
      end
      S_ARD:    fr_raddr = idx;
      S_ACHK:   fr_raddr = idx_step;
      S_AUPD: begin
        ur_we    = 1'b1;
        fr_we    = (nsz != '0);
        fr_waddr = idx;
        fr_wdata = {nst, nsz};
      end
      S_RM:     fr_raddr = FI'(FC'(k) + FC'(1));
      S_RMW: begin
        fr_we    = 1'b1;
        fr_waddr = k;
        fr_wdata = fr_rdata;
        fr_raddr = FI'((FC + 1)'(k) + (FC + 1)'(2));
      end
      S_FURD:   ur_raddr = uidx;
      S_FUCHK:  ur_raddr = uidx + UI'(1);
      S_FPRD:   fr_raddr = idx;
      S_FPCHK:  fr_raddr = idx + FI'(1);
      S_FMRG: begin
        priority if (lo && hi) begin
          fr_we    = 1'b1;
          fr_waddr = FI'(pos - FC'(1));
          fr_wdata = {pv_s, pv_z + z + hi_z};
        end else if (lo) begin
          fr_we    = 1'b1;
          fr_waddr = FI'(pos - FC'(1));
          fr_wdata = {pv_s, pv_z + z};
        end else if (hi) begin
          fr_we    = 1'b1;
          fr_waddr = FI'(pos);
          fr_wdata = {s, hi_z + z};
        end else begin
          fr_raddr = FI'(cnt - FC'(1));
        end
      end
      S_INSW: begin
        fr_we    = 1'b1;
        fr_waddr = k;
        fr_wdata = fr_rdata;
        fr_raddr = k - FI'(2);
      end
      S_INSPUT: begin
        fr_we    = 1'b1;
        fr_waddr = FI'(pos);
        fr_wdata = {s, z};
      end
      S_SUMRD:  fr_raddr = '0;
      S_SUMCHK: fr_raddr = idx + FI'(1);
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cnt        <= '0;
      used_valid <= '0;
      used_total <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_INIT, S_CLR: begin
          cnt        <= clr_fill ? FC'(1) : FC'(0);
          used_valid <= '0;
          used_total <= '0;
        end
        S_AUPD: begin
          used_valid[slot] <= 1'b1;
          used_total       <= used_total + UC'(1);
        end
        S_RM: if ((FC'(k) + FC'(1)) >= cnt) cnt <= cnt - FC'(1);
        S_RMW: begin
          if (!((FC + 1)'(k) + (FC + 1)'(2) < (FC + 1)'(cnt))) cnt <= cnt - FC'(1);
        end
        S_FMRG: begin
          if (lo || hi || cnt < FC'(FREE_SEGS)) begin
            used_valid[uidx] <= 1'b0;
            if (used_total != '0) used_total <= used_total - UC'(1);
          end
        end
        S_INSPUT: cnt <= cnt + FC'(1);
        S_SUMRD:  if (cnt == '0) done <= 1'b1;
        S_SUMCHK: if (sum_last) done <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        act  <= action;
        need <= need_in;
        ptr  <= pointer;
        addr <= '0;
        idx  <= (action_t'(action) == ACT_ALLOC_REAR) ? FI'(cnt - FC'(1)) : '0;
        uidx <= '0;
        st   <= ST_OK;
        if ((action_t'(action) == ACT_ALLOC_FRONT || action_t'(action) == ACT_ALLOC_REAR)
            && (need_in == '0 || cnt == '0)) st <= ST_NO_FIT;
      end
      S_ACHK: begin
        if (fit) begin
          hs <= frd_s;
          hz <= frd_z;
        end else if (a_last) begin
          st <= ST_NO_FIT;
        end else begin
          idx <= idx_step;
        end
      end
      S_SLOT: begin
        if (!used_valid[uidx]) slot <= uidx;
        else if (uidx == UI'(USED_BLOCKS - 1)) st <= ST_FULL;
        else uidx <= uidx + UI'(1);
      end
      S_AUPD: begin
        addr <= cfg.heap_base + 32'(blk) + 32'(cfg.header_bytes);
        k    <= idx;
      end
      S_RMW: k <= k + FI'(1);
      S_FUCHK: begin
        if (u_match) begin
          s         <= urd_s;
          z         <= urd_z;
          idx       <= '0;
          have_prev <= 1'b0;
          pos       <= '0;
          lo        <= 1'b0;
          hi        <= 1'b0;
        end else if (uidx == UI'(USED_BLOCKS - 1)) begin
          st <= ST_UNKNOWN;
        end else begin
          uidx <= uidx + UI'(1);
        end
      end
      S_FPCHK: begin
        if (s < frd_s) begin
          pos  <= FC'(idx);
          hi   <= (blk_end == {1'b0, frd_s});
          hi_z <= frd_z;
          lo   <= have_prev && (pv_end == {1'b0, s});
        end else begin
          pv_s      <= frd_s;
          pv_z      <= frd_z;
          have_prev <= 1'b1;
          if ((FC'(idx) + FC'(1)) == cnt) begin
            pos <= cnt;
            hi  <= 1'b0;
            lo  <= (dat_end == {1'b0, s});
          end else begin
            idx <= idx + FI'(1);
          end
        end
      end
      S_FMRG: begin
        if (lo && hi) k <= FI'(pos);
        else if (!lo && !hi) begin
          if (cnt >= FC'(FREE_SEGS)) st <= ST_FULL;
          else k <= FI'(cnt);
        end
      end
      S_INSW: k <= k - FI'(1);
      S_SUMRD: begin
        idx <= '0;
        mx  <= '0;
        tot <= '0;
        if (cnt == '0) begin
          status     <= st;
          address    <= (st == ST_OK) ? addr : 32'd0;
          max_free   <= '0;
          total_free <= '0;
          used_count <= 5'(used_total);
        end
      end
      S_SUMCHK: begin
        mx  <= m2;
        tot <= t2;
        idx <= idx + FI'(1);
        if (sum_last) begin
          status     <= st;
          address    <= (st == ST_OK) ? addr : 32'd0;
          max_free   <= 21'(m2);
          total_free <= t2[20:0];
          used_count <= 5'(used_total);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/coalescing_segment_allocator.sv
// Coalescing segment allocator: first-fit heap manager with free-segment merging.
//
// Request channel: drive action and its operands with start high; the request
// is taken at a rising edge where start is high and busy is low. Actions are
// alloc from front, alloc from rear, free a pointer, and clear the heap.
// Result channel: done pulses for one cycle with status, address, max_free,
// total_free and used_count; the receiver cannot stall, so take it then.
// Timing: both tables sit in memories with a registered read, and every
// request walks them one entry per cycle. An alloc compares free entries
// until one fits, checks used slots for a free one, and shifts the free table
// when the hit segment is used up; a free checks used slots for the pointer,
// compares free entries, and shifts the free table on a two-sided merge or to
// insert a new segment. Every request, also a clear, a null pointer, zero need
// or an empty table, ends with a pass that sums the free segments for the max
// and total. done is high in the cycle busy drops. One request at a time.
// Configuration: APB write of heap_base, heap_size, info_bytes, header_bytes
// at 0x0/0x4/0x8/0xC while idle; heap_size and info_bytes take effect at the
// next clear, header_bytes at the next alloc or free.
// Reset: synchronous; the S_INIT state then sets up the heap as a single free segment.
`default_nettype none

module coalescing_segment_allocator
  import csa_pkg::*;
#(
  parameter int FREE_SEGS   = FREE_SEGS_DEF,
  parameter int USED_BLOCKS = USED_BLOCKS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  action,
  input  wire logic [20:0] request_size,
  input  wire logic [12:0] align_bytes,
  input  wire logic [31:0] pointer,
  output      logic        done,
  output      logic [1:0]  status,
  output      logic [31:0] address,
  output      logic [20:0] max_free,
  output      logic [20:0] total_free,
  output      logic [4:0]  used_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  // largest heap size the offset width can hold
  localparam logic [31:0] HS_LIM = (OFFSET_BITS >= 21) ? 32'h001F_FFFF
                                                       : ((32'd1 << OFFSET_BITS) - 32'd1);

  cfg_t       cfg;
  logic       wr_en;
  reg_idx_t   ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  // register write; clamp heap size to the offset range
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base    <= HEAP_BASE_RST;
      cfg.heap_size    <= HEAP_SIZE_RST;
      cfg.info_bytes   <= INFO_BYTES_RST;
      cfg.header_bytes <= HEADER_BYTES_RST;
    end else if (wr_en) begin
      unique case (ridx)
        REG_HEAP_BASE:    cfg.heap_base <= pwdata;
        REG_HEAP_SIZE: begin
          cfg.heap_size <= (32'(pwdata[20:0]) > HS_LIM) ? HS_LIM[20:0] : pwdata[20:0];
        end
        REG_INFO_BYTES:   cfg.info_bytes   <= pwdata[8:0];
        REG_HEADER_BYTES: cfg.header_bytes <= pwdata[8:0];
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (ridx)
      REG_HEAP_BASE:    prdata = cfg.heap_base;
      REG_HEAP_SIZE:    prdata = 32'(cfg.heap_size);
      REG_INFO_BYTES:   prdata = 32'(cfg.info_bytes);
      REG_HEADER_BYTES: prdata = 32'(cfg.header_bytes);
    endcase
  end

  // table walker, merge logic and both memories
  csa_core #(
    .FREE_SEGS(FREE_SEGS),
    .USED_BLOCKS(USED_BLOCKS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .start(start),
    .busy(busy),
    .action(action),
    .request_size(request_size),
    .align_bytes(align_bytes),
    .pointer(pointer),
    .done(done),
    .status(status),
    .address(address),
    .max_free(max_free),
    .total_free(total_free),
    .used_count(used_count)
  );

endmodule

`default_nettype wire
